// ----- hdl/lic_pkg.sv -----
// shared constants, types and state codes of the line border clipper
package lic_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM = 4096;
  localparam int REGW = 13;
  localparam int CW = 16;
  localparam int OW = 12;
  localparam int DIMW = $clog2(MAX_DIM) + 1;
  localparam int QB = DIMW;
  localparam int SW = 22 + FRAC_BITS;
  localparam int BW = SW + CW + 1;
  localparam int NW = BW + 1;
  localparam int DIVW = NW;
  localparam int QW = CW + 1 + FRAC_BITS;
  localparam int STW = $clog2(QW + 1);

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
  } item_t;

  typedef struct packed {
    logic           start;
    logic [STW-1:0] steps;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLOPE, ST_SDIV, ST_MUL, ST_BASE, ST_YR, ST_EDGE, ST_EDIV, ST_OUT
  } state_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_e;

endpackage

// ----- hdl/lic_front.sv -----
// input side: takes point pairs, forms dx and dy, holds them in a two-entry queue
module lic_front import lic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [4*CW-1:0]     in_data_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output item_t               q_item_o
);

  item_t       mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       new_item;
  logic signed [CW-1:0] x1, y1, x2, y2;

  assign x1 = in_data_i[CW-1:0];
  assign y1 = in_data_i[2*CW-1:CW];
  assign x2 = in_data_i[3*CW-1:2*CW];
  assign y2 = in_data_i[4*CW-1:3*CW];

  always_comb begin
    new_item.x1 = x1;
    new_item.y1 = y1;
    new_item.dx = (CW+1)'(x2) - (CW+1)'(x1);
    new_item.dy = (CW+1)'(y2) - (CW+1)'(y1);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q ^ push;
    rd_d = rd_q ^ (q_pop_i && q_valid_o);
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count missed a push");

endmodule

// ----- hdl/lic_div.sv -----
// shared restoring divider, one quotient bit per cycle from a preshifted divisor
module lic_div import lic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  input  logic [DIVW-1:0]   num_i,
  input  logic [DIVW-1:0]   den_i,
  output logic              done_o,
  output logic [QW-1:0]     quo_o
);

  logic [DIVW-1:0] rem_q, dsh_q;
  logic [QW-1:0]   quo_q;
  logic [STW-1:0]  cnt_q;
  logic            busy_q, done_q;
  logic            ge;

  assign ge = (rem_q >= dsh_q);
  assign done_o = done_q;
  assign quo_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STW'(1);
      if (cnt_q == STW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= num_i;
      dsh_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");

endmodule

// ----- hdl/lic_back.sv -----
// sequencer: slope, intercept, the edge tests on top, left, bottom and right, and the result register
module lic_back import lic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  item_t             q_item_i,
  input  logic [DIMW-1:0]   rows_i,
  input  logic [DIMW-1:0]   cols_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4*OW-1:0]   out_data_o,
  output logic              out_flag_o
);

  state_e state_q, state_d;
  item_t  item_q;
  logic signed [SW-1:0]      s_q, s_d;
  logic signed [SW+CW-1:0]   p_q;
  logic signed [SW+DIMW:0]   t_q;
  logic [SW+DIMW-2:0]        cs_q;
  logic signed [BW-1:0]      b_q;
  logic signed [NW-1:0]      yr_q;
  logic [1:0]                k_q, k_d, n_q, n_d;
  logic [DIMW-1:0]           px_q [2];
  logic [DIMW-1:0]           py_q [2];
  logic                      out_valid_q;
  logic [4*OW-1:0]           out_data_q;
  logic                      out_flag_q;

  div_req_t              dreq;
  logic [DIVW-1:0]       dnum, dden;
  logic                  ddone;
  logic [QW-1:0]         dquo;

  logic [DIMW-1:0]       rows_m1, cols_m1;
  logic [CW:0]           abs_dx, abs_dy;
  logic [SW-2:0]         abs_s;
  logic signed [SW-1:0]  dy_ext, s_dz, s_div;
  logic signed [NW-1:0]  b_ext, num, yq;
  logic [NW-1:0]         abs_num;
  logic                  nonneg, far, s_zero, hit_v;
  logic                  rec, adv, load_out, f;
  logic [DIMW-1:0]       rx, ry;

  lic_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .num_i  (dnum),
    .den_i  (dden),
    .done_o (ddone),
    .quo_o  (dquo)
  );

  always_comb begin
    rows_m1 = rows_i - DIMW'(1);
    cols_m1 = cols_i - DIMW'(1);
    abs_dx = item_q.dx[CW] ? -item_q.dx : item_q.dx;
    abs_dy = item_q.dy[CW] ? -item_q.dy : item_q.dy;
    dy_ext = SW'(item_q.dy);
    // dx of zero stands for 0.05, so the slope is dy times twenty
    s_dz = (dy_ext <<< (FRAC_BITS + 4)) + (dy_ext <<< (FRAC_BITS + 2));
    s_div = (item_q.dy[CW] ^ item_q.dx[CW]) ? -SW'(dquo) : SW'(dquo);
    abs_s = s_q[SW-1] ? (SW-1)'(-s_q) : (SW-1)'(s_q);
    s_zero = (s_q == '0);
    b_ext = NW'(b_q);
    if (k_q == 2'd0) begin
      num = -b_ext;
    end else begin
      num = $signed({{(NW-DIMW-FRAC_BITS){1'b0}}, rows_m1, {FRAC_BITS{1'b0}}}) - b_ext;
    end
    nonneg = (num == '0) || (num[NW-1] == s_q[SW-1]);
    abs_num = num[NW-1] ? -num : num;
    far = (abs_num >= NW'(cs_q));
    yq = (k_q == 2'd1) ? b_ext : yr_q;
    hit_v = !yq[NW-1] && (yq[NW-1:FRAC_BITS] < (NW-FRAC_BITS)'(rows_i));
  end

  always_comb begin
    state_d = state_q;
    s_d = s_q;
    k_d = k_q;
    n_d = n_q;
    q_pop_o = 1'b0;
    dreq.start = 1'b0;
    dreq.steps = STW'(QW);
    dnum = DIVW'(abs_dy) << FRAC_BITS;
    dden = DIVW'(abs_dx) << (QW - 1);
    rec = 1'b0;
    adv = 1'b0;
    rx = '0;
    ry = '0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (item_q.dx == '0) begin
          s_d = s_dz;
          state_d = ST_MUL;
        end else begin
          dreq.start = 1'b1;
          state_d = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (ddone) begin
          s_d = s_div;
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_BASE;
      ST_BASE: state_d = ST_YR;
      ST_YR: begin
        k_d = 2'd0;
        n_d = 2'd0;
        state_d = ST_EDGE;
      end
      ST_EDGE: begin
        if (!k_q[0]) begin
          // top and bottom edges are skipped for a horizontal line
          if (s_zero || !nonneg || far) begin
            adv = 1'b1;
          end else begin
            dreq.start = 1'b1;
            dreq.steps = STW'(QB);
            dnum = abs_num;
            dden = DIVW'(abs_s) << (QB - 1);
            state_d = ST_EDIV;
          end
        end else begin
          rec = hit_v;
          rx = (k_q == 2'd1) ? '0 : cols_m1;
          ry = DIMW'(yq[NW-1:FRAC_BITS]);
          adv = 1'b1;
        end
      end
      ST_EDIV: begin
        if (ddone) begin
          rec = 1'b1;
          rx = DIMW'(dquo);
          ry = (k_q == 2'd0) ? '0 : rows_m1;
          adv = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (rec && (n_q != 2'd2)) begin
      n_d = n_q + 2'd1;
    end
    if (adv) begin
      k_d = k_q + 2'd1;
      state_d = (k_q == 2'd3) ? ST_OUT : ST_EDGE;
    end
  end

  // smaller x goes first, a tie puts the second crossing first
  assign f = !(px_q[0] < px_q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q <= 2'd0;
      n_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      n_q <= n_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    s_q <= s_d;
    if (state_q == ST_MUL) begin
      p_q <= s_q * item_q.x1;
      t_q <= s_q * $signed({1'b0, cols_m1});
      cs_q <= abs_s * cols_i;
    end
    if (state_q == ST_BASE) begin
      b_q <= ($signed(BW'(item_q.y1)) <<< FRAC_BITS) - BW'(p_q);
    end
    if (state_q == ST_YR) begin
      yr_q <= NW'(t_q) + NW'(b_q);
    end
    if (rec && (n_q != 2'd2)) begin
      px_q[n_q[0]] <= rx;
      py_q[n_q[0]] <= ry;
    end
    if (load_out) begin
      if (n_q == 2'd2) begin
        out_data_q <= {py_q[!f][OW-1:0], px_q[!f][OW-1:0],
                       py_q[f][OW-1:0], px_q[f][OW-1:0]};
        out_flag_q <= 1'b1;
      end else begin
        out_data_q <= '0;
        out_flag_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;
  assign out_flag_o = out_flag_q;

  a_hits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q != 2'd3) else $error("more than two crossings kept");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result overwritten");

endmodule

// ----- hdl/line_image_border_clip.sv -----
// top level: register port, input queue, clipping sequencer and result register
// each transaction passes the states idle, slope, mul, base, yr, edge for each border and out;
//   a slope division comes in when dx is nonzero, and an edge division per top or bottom crossing
// the single shared divider serves one line at a time; the next line is taken after the result
// the two-entry input queue and the result register let both sides stall freely
// reset (asynchronous, active low) empties the queue and sets rows 480, cols 640
module line_image_border_clip import lic_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [4*CW-1:0]   s_axis_tdata_i,   // first_x, first_y, second_x, second_y
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [4*OW-1:0]   m_axis_tdata_o,   // start_x, start_y, end_x, end_y
  output logic              m_axis_tuser_o,   // valid_res
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [REGW-1:0] rows_q, cols_q;
  logic [DIMW-1:0] rows_sat, cols_sat;
  logic            wr_en;
  logic            q_valid, q_pop;
  item_t           q_item;
  reg_idx_e        idx;

  function automatic logic [DIMW-1:0] sat_dim(input logic [REGW-1:0] v);
    logic [DIMW-1:0] r;
    if (int'(v) < 2) begin
      r = DIMW'(2);
    end else if (int'(v) > MAX_DIM) begin
      r = DIMW'(MAX_DIM);
    end else begin
      r = DIMW'(v);
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign idx = reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= REGW'(480);
      cols_q <= REGW'(640);
    end else if (wr_en) begin
      unique case (idx)
        REG_ROWS: rows_q <= pwdata[REGW-1:0];
        REG_COLS: cols_q <= pwdata[REGW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROWS: prdata = 32'(rows_q);
      REG_COLS: prdata = 32'(cols_q);
      default: prdata = '0;
    endcase
  end

  assign rows_sat = sat_dim(rows_q);
  assign cols_sat = sat_dim(cols_q);

  lic_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  lic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .rows_i      (rows_sat),
    .cols_i      (cols_sat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_flag_o  (m_axis_tuser_o)
  );

endmodule

// ----- dv/line_image_border_clip_checker.sv -----
// checker for the line border clipper: watches both streams and the register port,
// predicts each result and compares it with what the block returns
module line_image_border_clip_checker import lic_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  input  logic            s_axis_tready_i,
  input  logic [4*CW-1:0] s_axis_tdata_i,   // first_x, first_y, second_x, second_y
  input  logic            m_axis_tvalid_i,
  input  logic            m_axis_tready_i,
  input  logic [4*OW-1:0] m_axis_tdata_i,   // start_x, start_y, end_x, end_y
  input  logic            m_axis_tuser_i,   // valid_res
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int              errors_o,
  output int              pending_o,
  output int              results_o,
  output int              clipped_o
);

  localparam logic [2:0] ADDR_ROWS = 3'(4 * REG_ROWS);
  localparam logic [2:0] ADDR_COLS = 3'(4 * REG_COLS);
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint DX_ZERO_RECIP = 20;

  typedef struct packed {
    logic [OW-1:0] start_x;
    logic [OW-1:0] start_y;
    logic [OW-1:0] end_x;
    logic [OW-1:0] end_y;
    logic          hit;
  } segment_t;

  logic [REGW-1:0] rows_q, cols_q;
  segment_t        expected_segments[$];
  int              errors, results, clipped;

  function automatic longint clamp_dim(logic [REGW-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  // crossing of a horizontal edge, x = num / slope
  function automatic bit cross_row(longint num, longint slope, longint cols,
                                   output longint x);
    longint q;
    x = 0;
    if (!(num == 0 || ((num > 0) == (slope > 0)))) return 0;
    q = num / slope;
    if (q < 0) q = -q;
    if (q >= cols) return 0;
    x = q;
    return 1;
  endfunction

  // crossing of a vertical edge, y in fixed point
  function automatic bit cross_col(longint yq, longint rows, output longint y);
    y = 0;
    if (yq < 0) return 0;
    if (yq / ONE >= rows) return 0;
    y = yq / ONE;
    return 1;
  endfunction

  function automatic segment_t clip_line(logic [4*CW-1:0] d,
                                         logic [REGW-1:0] rows_r, logic [REGW-1:0] cols_r);
    longint x1, y1, x2, y2, rows, cols, dx, dy, slope, icpt, cx, cy;
    longint px[2], py[2];
    int n, f;
    bit hit;
    segment_t r;
    x1 = longint'($signed(d[15:0]));
    y1 = longint'($signed(d[31:16]));
    x2 = longint'($signed(d[47:32]));
    y2 = longint'($signed(d[63:48]));
    rows = clamp_dim(rows_r);
    cols = clamp_dim(cols_r);
    dx = x2 - x1;
    dy = y2 - y1;
    slope = (dx == 0) ? dy * DX_ZERO_RECIP * ONE : (dy * ONE) / dx;
    icpt = y1 * ONE - slope * x1;
    n = 0;
    px = '{0, 0};
    py = '{0, 0};
    // edges in the order top, left, bottom, right
    for (int k = 0; k < 4; k++) begin
      hit = 0;
      cx = 0;
      cy = 0;
      case (k)
        0: if (slope != 0) hit = cross_row(-icpt, slope, cols, cx);
        1: hit = cross_col(icpt, rows, cy);
        2: if (slope != 0) begin
          hit = cross_row((rows - 1) * ONE - icpt, slope, cols, cx);
          cy = rows - 1;
        end
        default: begin
          hit = cross_col(slope * (cols - 1) + icpt, rows, cy);
          cx = cols - 1;
        end
      endcase
      if (hit && n < 2) begin
        px[n] = cx;
        py[n] = cy;
        n++;
      end
    end
    r = '0;
    if (n == 2) begin
      f = (px[0] < px[1]) ? 0 : 1;
      r.start_x = OW'(px[f]);
      r.start_y = OW'(py[f]);
      r.end_x = OW'(px[1-f]);
      r.end_y = OW'(py[1-f]);
      r.hit = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    segment_t got, want;
    if (!rst_ni) begin
      rows_q <= 13'd480;
      cols_q <= 13'd640;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_ROWS) rows_q <= pwdata[REGW-1:0];
        else if (paddr == ADDR_COLS) cols_q <= pwdata[REGW-1:0];
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_segments.insert(expected_segments.size(),
                                 clip_line(s_axis_tdata_i, rows_q, cols_q));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[11:0], m_axis_tdata_i[23:12], m_axis_tdata_i[35:24],
               m_axis_tdata_i[47:36], m_axis_tuser_i};
        results++;
        if (expected_segments.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h", got);
        end else begin
          want = expected_segments.pop_front();
          if (want.hit) clipped++;
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: start (%0d,%0d) end (%0d,%0d) valid %0b, expected (%0d,%0d) (%0d,%0d) %0b",
                       got.start_x, got.start_y, got.end_x, got.end_y, got.hit,
                       want.start_x, want.start_y, want.end_x, want.end_y, want.hit);
          end
        end
      end
    end
  end

  assign errors_o = errors;
  assign pending_o = expected_segments.size();
  assign results_o = results;
  assign clipped_o = clipped;

endmodule

// ----- dv/line_image_border_clip_test.sv -----
// testbench top of the line border clipper: stimulus, idling, watchdog and verdict
module line_image_border_clip_test;
  import lic_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 150;

  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            s_axis_tvalid_i = 0;
  logic            s_axis_tready_o;
  logic [4*CW-1:0] s_axis_tdata_i = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 0;
  logic [4*OW-1:0] m_axis_tdata_o;
  logic            m_axis_tuser_o;
  logic            psel = 0, penable = 0, pwrite = 0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  int errors, pending, results, clipped;
  int sent, burst_left, idle_cycles;
  bit hold_off_req;
  logic [REGW-1:0] cur_rows = 480, cur_cols = 640;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  line_image_border_clip dut (.*);

  line_image_border_clip_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending), .results_o(results), .clipped_o(clipped)
  );

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 0;
        m_axis_tready_i = 0;
        repeat (400) @(negedge clk_i);
      end
      mode = (sent / 100) % 3;
      if (mode == 0) m_axis_tready_i = 1;
      else if (mode == 1) m_axis_tready_i = ($urandom_range(0, 3) != 0);
      else m_axis_tready_i = ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_line(logic [CW-1:0] x1, logic [CW-1:0] y1,
                           logic [CW-1:0] x2, logic [CW-1:0] y2);
    if (burst_left == 0) begin
      s_axis_tvalid_i = 0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 90) : 0) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid_i = 1;
    s_axis_tdata_i = {y2, x2, y1, x1};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    burst_left--;
    sent++;
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic set_frame(logic [REGW-1:0] rows, logic [REGW-1:0] cols);
    s_axis_tvalid_i = 0;
    burst_left = 0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    apb_write(3'(4 * REG_ROWS), 32'(rows));
    apb_write(3'(4 * REG_COLS), 32'(cols));
    cur_rows = rows;
    cur_cols = cols;
  endtask

  function automatic logic [CW-1:0] near(int span);
    return CW'($urandom_range(0, span + 100) - 50);
  endfunction

  task automatic random_lines(int count);
    int r, h, w;
    h = (cur_rows < 2) ? 2 : (cur_rows > MAX_DIM ? MAX_DIM : cur_rows);
    w = (cur_cols < 2) ? 2 : (cur_cols > MAX_DIM ? MAX_DIM : cur_cols);
    for (int i = 0; i < count; i++) begin
      logic [CW-1:0] x1, y1, x2, y2;
      r = $urandom_range(0, 99);
      x1 = near(w);
      y1 = near(h);
      x2 = near(w);
      y2 = near(h);
      if (r < 10) x2 = x1;                                  // vertical
      else if (r < 20) y2 = y1;                             // horizontal
      else if (r < 25) y2 = y1 + CW'($urandom_range(0, 3)); // nearly flat
      else if (r < 40) begin
        x1 = $urandom;
        y1 = $urandom;
        x2 = $urandom;
        y2 = $urandom;
      end
      send_line(x1, y1, x2, y2);
    end
  endtask

  initial begin
    logic [REGW-1:0] rr, cc;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed lines on the reset frame of 480 rows by 640 columns
    send_line(0, 0, 1, 1);                // diagonal through a corner
    send_line(0, 0, 639, 479);            // through two corners
    send_line(10, 100, 20, 100);          // horizontal inside
    send_line(10, 479, 600, 479);         // horizontal on bottom edge
    send_line(320, 5, 320, 400);          // vertical, dx zero rule
    send_line(0, 0, 0, 10);               // vertical on left edge
    send_line(100, 200, 101, 200);        // horizontal, single step
    send_line(0, 1, 1000, 2);             // slope truncates to a small value
    send_line(-32768, -32768, 32767, 32767);
    send_line(32767, -32768, -32768, 32767);
    send_line(-32768, 0, 32767, 0);
    send_line(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_line(1000, 1000, 2000, 3000);    // misses the frame
    send_line(-5, -5, -10, -20);          // misses the frame
    send_line(639, 0, 0, 479);            // anti diagonal through corners
    send_line(100, 0, 100, 0);            // identical points
    send_line(0, 240, 640, 240);
    send_line(320, 0, 330, 479);          // steep, same truncated x
    send_line(5, -3, 7, 1000);
    send_line(-1, 0, 1, 0);

    random_lines(60);
    hold_off_req = 1;                      // receiver holds off while lines keep coming
    random_lines(60);

    set_frame(2, 2);
    send_line(0, 0, 1, 1);
    send_line(0, 1, 1, 0);
    random_lines(80);
    set_frame(4096, 4096);
    send_line(0, 0, 4095, 4095);
    send_line(0, 4095, 4095, 0);
    random_lines(100);
    set_frame(0, 8191);                    // saturated into range
    random_lines(80);
    set_frame(4097, 1);
    random_lines(80);
    set_frame(37, 100);
    random_lines(120);
    for (int p = 0; p < 6; p++) begin
      rr = $urandom_range(0, 3) == 0 ? REGW'($urandom) : REGW'($urandom_range(2, 700));
      cc = $urandom_range(0, 3) == 0 ? REGW'($urandom) : REGW'($urandom_range(2, 900));
      set_frame(rr, cc);
      random_lines(100);
    end
    set_frame(480, 640);
    random_lines(60);

    s_axis_tvalid_i = 0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("sent %0d lines over 13 frame sizes including saturated ones", sent);
    $display("%0d results checked, %0d clipped to a segment, %0d errors",
             results, clipped, errors);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lic_pkg.sv
hdl/lic_front.sv
hdl/lic_div.sv
hdl/lic_back.sv
hdl/line_image_border_clip.sv
dv/line_image_border_clip_checker.sv
dv/line_image_border_clip_test.sv
